>>> src/frt_pkg.sv
// ----------------------------------------------------------------------------
// frt_pkg
// Shared types and constants for the fragment reassembly tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package frt_pkg;

    // outcome codes
    localparam logic [2:0] OC_FILTERED = 3'd0;
    localparam logic [2:0] OC_WAITING  = 3'd1;
    localparam logic [2:0] OC_BREAK    = 3'd2;
    localparam logic [2:0] OC_STARTED  = 3'd3;
    localparam logic [2:0] OC_APPENDED = 3'd4;
    localparam logic [2:0] OC_COMPLETE = 3'd5;
    localparam logic [2:0] OC_FULL     = 3'd6;
    localparam logic [2:0] OC_TOO_LONG = 3'd7;

    // configuration register indexes
    localparam logic [1:0] CFG_TYPE_FILTER   = 2'd0;
    localparam logic [1:0] CFG_MODULE_FILTER = 2'd1;
    localparam logic [1:0] CFG_INST_FILTER   = 2'd2;

    localparam int          CFG_IDX_W  = 2;
    localparam int          FILTER_W   = 9;
    localparam logic [8:0]  FILTER_ANY = 9'h1FF;   // -1

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_TUSER_W = 3;
    localparam int SLOT_W      = 4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_RESOLVE,
        ST_COMMIT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;      // input beat accepted
        logic match;     // register CAM hit/free vectors and filter result
        logic resolve;   // priority-encode hit/free slots
        logic commit;    // update table, load output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_free;  // output register can take a result this cycle
    } t_status;

endpackage

`default_nettype wire

>>> src/frt_ctrl.sv
// ----------------------------------------------------------------------------
// frt_ctrl
// Sequencer: accept, CAM match, slot resolve, commit.
// ----------------------------------------------------------------------------
`default_nettype none

module frt_ctrl import frt_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_MATCH;
                end
            end
            ST_MATCH: begin
                o_cmd.match = 1'b1;
                n_state     = ST_RESOLVE;
            end
            ST_RESOLVE: begin
                o_cmd.resolve = 1'b1;
                n_state       = ST_COMMIT;
            end
            ST_COMMIT: begin
                // hold until the output register has room
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> src/frt_dp.sv
// ----------------------------------------------------------------------------
// frt_dp
// Datapath: filters, logo CAM, per-slot message state, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module frt_dp import frt_pkg::*; #(
    parameter int NUM_STREAMS       = 16,
    parameter int MAX_PAYLOAD_BYTES = 2047
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_cmd                   i_cmd,
    output t_status                     o_status,
    input  wire logic [IN_TDATA_W-1:0]  i_in_data,
    input  wire logic                   i_in_last,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [FILTER_W-1:0]    i_cfg_data,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic [OUT_TDATA_W-1:0]      o_out_data,
    output logic [OUT_TUSER_W-1:0]      o_out_user
);

    localparam int IW = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;

    // configuration
    logic [FILTER_W-1:0] r_type_f, r_mod_f, r_inst_f;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type_f <= FILTER_ANY;
            r_mod_f  <= FILTER_ANY;
            r_inst_f <= FILTER_ANY;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TYPE_FILTER:   r_type_f <= i_cfg_data;
                CFG_MODULE_FILTER: r_mod_f  <= i_cfg_data;
                CFG_INST_FILTER:   r_inst_f <= i_cfg_data;
                default: ;
            endcase
        end
    end

    function automatic logic f_pass(input logic [FILTER_W-1:0] f, input logic [7:0] v);
        f_pass = (f == FILTER_ANY) || (f == {1'b0, v});
    endfunction

    // captured header
    logic [7:0]  r_inst, r_type, r_mod, r_frag, r_seq;
    logic        r_last;
    logic [10:0] r_plen;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_inst <= i_in_data[7:0];
            r_type <= i_in_data[15:8];
            r_mod  <= i_in_data[23:16];
            r_frag <= i_in_data[31:24];
            r_seq  <= i_in_data[39:32];
            r_plen <= i_in_data[50:40];
            r_last <= i_in_last;
        end
    end

    logic [23:0] w_logo;
    assign w_logo = {r_inst, r_type, r_mod};

    // table
    logic [NUM_STREAMS-1:0] r_used, r_active, r_track;
    logic [23:0] r_logo    [NUM_STREAMS];
    logic [7:0]  r_cur_seq [NUM_STREAMS];
    logic [7:0]  r_exp_frag[NUM_STREAMS];
    logic [15:0] r_bytes   [NUM_STREAMS];
    logic [7:0]  r_exp_seq [NUM_STREAMS];

    // match stage
    logic [NUM_STREAMS-1:0] w_hit;
    logic [NUM_STREAMS-1:0] r_hit, r_free;
    logic                   r_pass;

    always_comb begin
        for (int i = 0; i < NUM_STREAMS; i++) begin
            w_hit[i] = r_used[i] && (r_logo[i] == w_logo);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.match) begin
            r_hit  <= w_hit;
            r_free <= ~r_used;
            r_pass <= f_pass(r_type_f, r_type) && f_pass(r_mod_f, r_mod) &&
                      f_pass(r_inst_f, r_inst);
        end
    end

    // resolve stage: lowest hit, lowest free
    logic [IW-1:0] w_hit_idx, w_free_idx;
    logic          w_found, w_has_free;
    logic [IW-1:0] r_slot, r_free_slot;
    logic          r_found, r_has_free;

    always_comb begin
        w_hit_idx  = '0;
        w_free_idx = '0;
        w_found    = 1'b0;
        w_has_free = 1'b0;
        for (int i = NUM_STREAMS - 1; i >= 0; i--) begin
            if (r_hit[i]) begin
                w_hit_idx = IW'(i);
                w_found   = 1'b1;
            end
            if (r_free[i]) begin
                w_free_idx = IW'(i);
                w_has_free = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.resolve) begin
            r_slot      <= w_hit_idx;
            r_found     <= w_found;
            r_free_slot <= w_free_idx;
            r_has_free  <= w_has_free;
        end
    end

    // commit stage
    logic [IW-1:0] w_idx;
    logic          w_act, w_new, w_break, w_ok, w_plen_big;
    logic [16:0]   w_sum;
    logic [15:0]   w_off, w_nbytes;
    logic [7:0]    w_nexp, w_lost;
    logic [2:0]    w_oc;
    logic [IW-1:0] w_oslot;
    logic [15:0]   w_len;
    logic          w_fire;

    assign w_idx      = r_found ? r_slot : r_free_slot;
    assign w_act      = r_found && r_active[r_slot];
    assign w_sum      = {1'b0, r_bytes[r_slot]} + {6'd0, r_plen};
    assign w_plen_big = {6'd0, r_plen} > 17'(MAX_PAYLOAD_BYTES);
    assign w_fire     = i_cmd.commit;

    always_comb begin
        w_new    = 1'b0;
        w_break  = 1'b0;
        w_ok     = 1'b0;
        w_off    = '0;
        w_nbytes = '0;
        w_nexp   = 8'd1;
        w_lost   = '0;
        w_len    = '0;
        w_oc     = OC_FILTERED;
        w_oslot  = '0;
        if (!r_pass) begin
            w_oc = OC_FILTERED;
        end else if (w_act) begin
            w_oslot = r_slot;
            if (r_seq != r_cur_seq[r_slot] || r_frag != r_exp_frag[r_slot]) begin
                w_break = 1'b1;
                w_oc    = OC_BREAK;
            end else if (w_plen_big || w_sum[16]) begin
                w_oc = OC_TOO_LONG;
            end else begin
                w_ok     = 1'b1;
                w_off    = r_bytes[r_slot];
                w_nbytes = w_sum[15:0];
                w_nexp   = r_exp_frag[r_slot] + 8'd1;
            end
        end else begin
            w_oslot = r_found ? r_slot : '0;
            if (r_frag != 8'd0) begin
                w_oc = OC_WAITING;
            end else if (w_plen_big) begin
                w_oc = OC_TOO_LONG;
            end else if (!r_found && !r_has_free) begin
                w_oc    = OC_FULL;
                w_oslot = '0;
            end else begin
                w_ok     = 1'b1;
                w_new    = !r_found;
                w_oslot  = w_idx;
                w_nbytes = {5'd0, r_plen};
                w_nexp   = 8'd1;
            end
        end
        if (w_ok) begin
            if (r_last) begin
                // new entries start untracked
                if (r_found && r_track[r_slot]) begin
                    w_lost = r_seq - r_exp_seq[r_slot];
                end
                w_len = w_nbytes;
                w_oc  = OC_COMPLETE;
            end else if (w_off == 16'd0 && r_frag == 8'd0 && w_nexp == 8'd1) begin
                w_oc = OC_STARTED;
            end else begin
                w_oc = OC_APPENDED;
            end
        end
    end

    // control bits of the table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used   <= '0;
            r_active <= '0;
            r_track  <= '0;
        end else if (w_fire) begin
            if (w_new) begin
                r_used[w_idx] <= 1'b1;
            end
            if (w_break) begin
                r_active[w_idx] <= 1'b0;
            end
            if (w_ok) begin
                r_active[w_idx] <= !r_last;
                if (r_last) begin
                    r_track[w_idx] <= 1'b1;
                end
            end
        end
    end

    // payload of the table
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            if (w_new) begin
                r_logo[w_idx] <= w_logo;
            end
            if (w_ok) begin
                r_cur_seq[w_idx]  <= r_seq;
                r_exp_frag[w_idx] <= w_nexp;
                r_bytes[w_idx]    <= w_nbytes;
                if (r_last) begin
                    r_exp_seq[w_idx] <= r_seq + 8'd1;
                end
            end
        end
    end

    // output register
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic [OUT_TUSER_W-1:0] r_out_user;
    logic [SLOT_W-1:0]      w_slot4;

    assign w_slot4           = SLOT_W'(w_oslot);
    assign o_status.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_user <= w_oc;
            r_out_data <= {3'd0, (w_lost != 8'd0), w_lost, w_len, w_off, w_slot4};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_user  = r_out_user;

endmodule

`default_nettype wire

>>> src/fragment_reassembly_tracker.sv
// Path: the header of an accepted input beat is registered, the match and resolve steps register
// their results, and commit loads the result beat. A new fragment header is accepted only once the
//   four-step sequencer (accept, CAM compare over all entries, lowest-slot encode, table commit) is done;
//   a result beat held by the receiver keeps the sequencer in commit.
// Reset: synchronous, active low; clears the table, filters go to accept-any (-1).
// No clearing pass: the stream table is ready the cycle after reset is released.
// ----------------------------------------------------------------------------
// fragment_reassembly_tracker
// Tracks fragment headers per source logo, reports offsets, completion and
// message loss counts.
// ----------------------------------------------------------------------------
`default_nettype none

module fragment_reassembly_tracker import frt_pkg::*; #(
    parameter int NUM_STREAMS       = 16,
    parameter int MAX_PAYLOAD_BYTES = 2047
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,

    // header input stream
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // tdata, from bit 0: installation_id[7:0], message_type[15:8], module_id[23:16],
    //   fragment_number[31:24], sequence_number[39:32], payload_length[50:40], zeros
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  wire logic                   s_axis_tlast,   // last_fragment

    // result stream
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // tdata, from bit 0: slot[3:0], write_offset[19:4], message_length[35:20],
    //   lost_messages[43:36], loss_seen[44], zeros
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // tuser: outcome[2:0]
    output logic [OUT_TUSER_W-1:0]      m_axis_tuser,

    // configuration writes: 0 type filter, 1 module filter, 2 installation filter
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [FILTER_W-1:0]    i_cfg_data
);

    t_cmd    w_cmd;
    t_status w_status;

    // filters are plain registers, a write always completes
    assign o_cfg_ready = 1'b1;

    frt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    frt_dp #(
        .NUM_STREAMS       (NUM_STREAMS),
        .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in_data   (s_axis_tdata),
        .i_in_last   (s_axis_tlast),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_out_user  (m_axis_tuser)
    );

endmodule

`default_nettype wire
